@@ design/centroid_bounding_sphere_macros.svh @@
// Assertion macros for the centroid bounding sphere block.
// Included by the top level; no other dependencies.
`ifndef CENTROID_BOUNDING_SPHERE_MACROS_SVH
`define CENTROID_BOUNDING_SPHERE_MACROS_SVH
`ifndef SYNTHESIS
`define CBS_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define CBS_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define CBS_ASSERT_IMPL(label, clk, rst, prop)
`define CBS_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ design/cbs_pkg.sv @@
// Shared types and constants for the centroid bounding sphere block.
// No dependencies.
package cbs_pkg;
   localparam int MaxVerts   = 1024;
   localparam int AddrW      = $clog2(MaxVerts);
   localparam int CountW     = $clog2(MaxVerts + 1);
   localparam int CoordW     = 24;
   localparam int SumW       = CoordW + CountW - 1;
   localparam int DiffW      = CoordW + 1;
   localparam int SqW        = 2 * CoordW;
   localparam int DistW      = SqW + 2;
   localparam int RadW       = 25;

   typedef enum logic [6:0] {
      ST_COLLECT = 7'b0000001,
      ST_DIV     = 7'b0000010,
      ST_SCAN    = 7'b0000100,
      ST_DRAIN   = 7'b0001000,
      ST_SQRT    = 7'b0010000,
      ST_OUT     = 7'b0100000,
      ST_START   = 7'b1000000   // sums now include the last vertex
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic store;      // store and sum input vertex
      logic clear;      // start a new mesh
      logic div_start;
      logic div_step;
      logic scan_rd;    // issue a store read
      logic sqrt_start;
      logic sqrt_step;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic div_done;
      logic scan_last;  // read address at final entry
      logic pipe_busy;  // scan pipeline still holds data
      logic sqrt_done;
   } status_type;
endpackage

@@ design/cbs_datapath.sv @@
// Datapath: vertex store, sums, serial divider, distance pipe and serial root.
// Depends on cbs_pkg.
module cbs_datapath
   import cbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic signed [CoordW-1:0] vx,
   input  logic signed [CoordW-1:0] vy,
   input  logic signed [CoordW-1:0] vz,
   input  logic                     in_ovf,
   output logic signed [CoordW-1:0] cx,
   output logic signed [CoordW-1:0] cy,
   output logic signed [CoordW-1:0] cz,
   output logic [RadW-1:0]          rad,
   output logic                     ovf
);
   localparam int DivStepsW = $clog2(SumW + 1);
   localparam int SqStepsW  = $clog2(DistW / 2 + 1);

   logic [3*CoordW-1:0] mem [MaxVerts];
   logic [3*CoordW-1:0] rd_ff;
   logic signed [SumW-1:0] sx_ff, sy_ff, sz_ff;
   logic [CountW-1:0] cnt_ff, rdp_ff;
   logic ovf_ff;

   // store write and per-axis sums; a vertex arriving at a full store is dropped
   always_ff @(posedge clock) begin
      if (cmd.store && !status.full) mem[cnt_ff[AddrW-1:0]] <= {vx, vy, vz};
      if (cmd.scan_rd) rd_ff <= mem[rdp_ff[AddrW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         sx_ff <= '0; sy_ff <= '0; sz_ff <= '0;
         cnt_ff <= '0; ovf_ff <= 1'b0;
      end else if (cmd.store) begin
         if (cnt_ff == CountW'(MaxVerts)) begin
            ovf_ff <= 1'b1;
         end else begin
            sx_ff <= sx_ff + SumW'(vx);
            sy_ff <= sy_ff + SumW'(vy);
            sz_ff <= sz_ff + SumW'(vz);
            cnt_ff <= cnt_ff + 1'b1;
         end
      end else if (in_ovf) begin
         ovf_ff <= 1'b1;
      end
   end
   assign status.full = (cnt_ff == CountW'(MaxVerts));
   assign ovf = ovf_ff;

   // restoring divider, three axes in parallel on magnitudes
   logic [SumW-1:0] qx_ff, qy_ff, qz_ff;
   logic [CountW-1:0] rx_ff, ry_ff, rz_ff;
   logic [DivStepsW-1:0] dstep_ff;
   logic nx_ff, ny_ff, nz_ff;

   function automatic logic [SumW-1:0] mag(input logic signed [SumW-1:0] v);
      mag = v[SumW-1] ? SumW'(-v) : v;
   endfunction

   function automatic logic [CountW:0] trial(input logic [CountW-1:0] r,
                                             input logic b, input logic [CountW-1:0] d);
      trial = {r, b} - {1'b0, d};
   endfunction

   logic [CountW:0] tx, ty, tz;
   assign tx = trial(rx_ff, qx_ff[SumW-1], cnt_ff);
   assign ty = trial(ry_ff, qy_ff[SumW-1], cnt_ff);
   assign tz = trial(rz_ff, qz_ff[SumW-1], cnt_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         qx_ff <= mag(sx_ff); qy_ff <= mag(sy_ff); qz_ff <= mag(sz_ff);
         nx_ff <= sx_ff[SumW-1]; ny_ff <= sy_ff[SumW-1]; nz_ff <= sz_ff[SumW-1];
         rx_ff <= '0; ry_ff <= '0; rz_ff <= '0;
         dstep_ff <= '0;
      end else if (cmd.div_step) begin
         dstep_ff <= dstep_ff + 1'b1;
         if (!tx[CountW]) begin
            rx_ff <= tx[CountW-1:0]; qx_ff <= {qx_ff[SumW-2:0], 1'b1};
         end else begin
            rx_ff <= {rx_ff[CountW-2:0], qx_ff[SumW-1]}; qx_ff <= {qx_ff[SumW-2:0], 1'b0};
         end
         if (!ty[CountW]) begin
            ry_ff <= ty[CountW-1:0]; qy_ff <= {qy_ff[SumW-2:0], 1'b1};
         end else begin
            ry_ff <= {ry_ff[CountW-2:0], qy_ff[SumW-1]}; qy_ff <= {qy_ff[SumW-2:0], 1'b0};
         end
         if (!tz[CountW]) begin
            rz_ff <= tz[CountW-1:0]; qz_ff <= {qz_ff[SumW-2:0], 1'b1};
         end else begin
            rz_ff <= {rz_ff[CountW-2:0], qz_ff[SumW-1]}; qz_ff <= {qz_ff[SumW-2:0], 1'b0};
         end
      end
   end
   assign status.div_done = (dstep_ff == DivStepsW'(SumW));

   // signed centroid, quotient magnitude fits the coordinate range
   logic signed [CoordW-1:0] cx_w, cy_w, cz_w;
   assign cx_w = nx_ff ? -CoordW'(qx_ff) : CoordW'(qx_ff);
   assign cy_w = ny_ff ? -CoordW'(qy_ff) : CoordW'(qy_ff);
   assign cz_w = nz_ff ? -CoordW'(qz_ff) : CoordW'(qz_ff);

   // scan: read, difference, square, sum, max
   logic v1_ff, v2_ff, v3_ff;
   logic [DiffW-1:0] dx_ff, dy_ff, dz_ff;
   logic [SqW-1:0] px_ff, py_ff, pz_ff;
   logic [DistW-1:0] max_ff;
   logic [DistW-1:0] dsum;
   logic signed [DiffW-1:0] ex, ey, ez;

   assign ex = DiffW'(signed'(rd_ff[3*CoordW-1:2*CoordW])) - DiffW'(cx_w);
   assign ey = DiffW'(signed'(rd_ff[2*CoordW-1:CoordW])) - DiffW'(cy_w);
   assign ez = DiffW'(signed'(rd_ff[CoordW-1:0])) - DiffW'(cz_w);
   assign dsum = DistW'(px_ff) + DistW'(py_ff) + DistW'(pz_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.div_start) begin
         rdp_ff <= '0;
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         max_ff <= '0;
      end else begin
         if (cmd.scan_rd) rdp_ff <= rdp_ff + 1'b1;
         v1_ff <= cmd.scan_rd;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (v3_ff && dsum > max_ff) max_ff <= dsum;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= ex[DiffW-1] ? DiffW'(-ex) : DiffW'(ex);
      dy_ff <= ey[DiffW-1] ? DiffW'(-ey) : DiffW'(ey);
      dz_ff <= ez[DiffW-1] ? DiffW'(-ez) : DiffW'(ez);
      px_ff <= SqW'(dx_ff * dx_ff);
      py_ff <= SqW'(dy_ff * dy_ff);
      pz_ff <= SqW'(dz_ff * dz_ff);
   end
   assign status.scan_last = (rdp_ff + 1'b1 >= cnt_ff);
   assign status.pipe_busy = v1_ff | v2_ff | v3_ff;

   // restoring square root, two bits per step
   logic [DistW-1:0] sn_ff;
   logic [RadW:0] root_ff;
   logic [RadW+2:0] srem_ff;
   logic [SqStepsW-1:0] sstep_ff;
   logic [RadW+2:0] strial;
   assign strial = {srem_ff[RadW:0], sn_ff[DistW-1 -: 2]} - {root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         sn_ff <= max_ff; root_ff <= '0; srem_ff <= '0; sstep_ff <= '0;
      end else if (cmd.sqrt_step) begin
         sn_ff <= {sn_ff[DistW-3:0], 2'b00};
         sstep_ff <= sstep_ff + 1'b1;
         if (!strial[RadW+2]) begin
            srem_ff <= strial; root_ff <= {root_ff[RadW-1:0], 1'b1};
         end else begin
            srem_ff <= {srem_ff[RadW:0], sn_ff[DistW-1 -: 2]};
            root_ff <= {root_ff[RadW-1:0], 1'b0};
         end
      end
   end
   assign status.sqrt_done = (sstep_ff == SqStepsW'(DistW / 2));

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         cx <= cx_w; cy <= cy_w; cz <= cz_w;
         rad <= root_ff[RadW-1:0];
      end
   end
endmodule

@@ design/cbs_control.sv @@
// Controller state machine sequencing collect, divide, scan, root and output.
// Depends on cbs_pkg.
module cbs_control
   import cbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       last_vertex,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd,
   output logic       out_ovf_load
);
   state_type state_ff, state_in;
   logic rv_ff, rv_in;
   logic take;

   assign req_ready = state_ff == ST_COLLECT;
   assign take = req_valid && req_ready;
   assign rsp_valid = rv_ff;

   // commands
   always_comb begin
      cmd = '0;
      cmd.store = take;
      cmd.div_start = state_ff == ST_START;
      cmd.div_step = state_ff == ST_DIV && !status.div_done;
      cmd.scan_rd = state_ff == ST_SCAN;
      cmd.sqrt_start = state_ff == ST_DRAIN && !status.pipe_busy;
      cmd.sqrt_step = state_ff == ST_SQRT && !status.sqrt_done;
      cmd.load_out = state_ff == ST_OUT;
      cmd.clear = state_ff == ST_OUT;
   end
   assign out_ovf_load = state_ff == ST_OUT;

   // next state
   always_comb begin
      state_in = state_ff;
      rv_in = rv_ff && !rsp_ready;
      case (state_ff)
         ST_COLLECT: if (take && last_vertex) state_in = ST_START;
         ST_START:   state_in = ST_DIV;
         ST_DIV:     if (status.div_done) state_in = ST_SCAN;
         ST_SCAN:    if (status.scan_last) state_in = ST_DRAIN;
         ST_DRAIN:   if (!status.pipe_busy) state_in = ST_SQRT;
         ST_SQRT:    if (status.sqrt_done && !rv_ff) state_in = ST_OUT;
         ST_OUT: begin
            state_in = ST_COLLECT;
            rv_in = 1'b1;
         end
         default:    state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
   end
endmodule

@@ design/centroid_bounding_sphere.sv @@
// Centroid bounding sphere of a streamed vertex list: each accepted vertex is
// written into the store; after the last vertex a start state lets the sums
// settle, then a 34-step serial divide, a scan of one store read per stored
// vertex followed by a drain of the pipeline, and a 25-step serial square
// root; the result then loads into an output register. Of this sequence only
// the scan grows with the number of stored vertices, since the single-port
// store is read one vertex at a time. Inputs are held off while a mesh
// computes, and the output load after the root waits while the previous
// result is still unaccepted on rsp_ready.
// Depends on cbs_pkg, cbs_control, cbs_datapath and the macros header.
`include "centroid_bounding_sphere_macros.svh"
module centroid_bounding_sphere
   import cbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_vertex_x,
   input  logic signed [23:0] req_vertex_y,
   input  logic signed [23:0] req_vertex_z,
   input  logic               req_last_vertex,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_center_x,
   output logic signed [23:0] rsp_center_y,
   output logic signed [23:0] rsp_center_z,
   output logic [24:0]        rsp_radius,
   output logic               rsp_overflow
);
   cmd_type cmd;
   status_type status;
   logic out_ovf_load, dp_ovf, ovf_ff;

   cbs_control u_ctl (
      .clock, .reset, .req_valid, .req_ready,
      .last_vertex(req_last_vertex), .rsp_valid, .rsp_ready,
      .status, .cmd, .out_ovf_load
   );

   cbs_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .vx(req_vertex_x), .vy(req_vertex_y), .vz(req_vertex_z), .in_ovf(1'b0),
      .cx(rsp_center_x), .cy(rsp_center_y), .cz(rsp_center_z),
      .rad(rsp_radius), .ovf(dp_ovf)
   );

   // overflow flag of the delivered mesh
   always_ff @(posedge clock) begin
      if (out_ovf_load) ovf_ff <= dp_ovf;
   end
   assign rsp_overflow = ovf_ff;

   `CBS_ASSERT_IMPL(a_no_accept_busy, clock, reset, cmd.div_step |-> !req_ready)
   `CBS_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `CBS_ASSERT_RST(a_reset_idle, clock, reset |=> !rsp_valid)
endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for centroid_bounding_sphere: streams vertex meshes,
// predicts centroid, radius and overflow in-line, and checks every response.
// Depends on cbs_pkg and the centroid_bounding_sphere RTL.
module tb_top;
   import cbs_pkg::*;

   localparam int CycleLimit = 1000000;
   localparam int StoreDepth = 1024;
   localparam int RandomVerts = 437;

   typedef struct {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      logic               last;
   } vertex_type;

   typedef struct {
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic signed [23:0] cz;
      logic [24:0]        radius;
      logic               overflow;
   } sphere_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [23:0] req_vertex_x = '0;
   logic signed [23:0] req_vertex_y = '0;
   logic signed [23:0] req_vertex_z = '0;
   logic               req_last_vertex = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [23:0] rsp_center_x;
   logic signed [23:0] rsp_center_y;
   logic signed [23:0] rsp_center_z;
   logic [24:0]        rsp_radius;
   logic               rsp_overflow;

   vertex_type vertex_queue[$];
   sphere_type sphere_queue[$];

   // predictor state for the mesh in progress
   logic signed [23:0] mesh_x[StoreDepth];
   logic signed [23:0] mesh_y[StoreDepth];
   logic signed [23:0] mesh_z[StoreDepth];
   longint mesh_sum_x, mesh_sum_y, mesh_sum_z;
   int     mesh_count;
   bit     mesh_dropped;

   int mismatch_count = 0;
   int meshes_checked = 0;
   int overflow_meshes = 0;
   int verts_sent = 0;
   int cycle_count = 0;

   centroid_bounding_sphere uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_vertex_x(req_vertex_x), .req_vertex_y(req_vertex_y),
      .req_vertex_z(req_vertex_z), .req_last_vertex(req_last_vertex),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_center_x(rsp_center_x), .rsp_center_y(rsp_center_y),
      .rsp_center_z(rsp_center_z), .rsp_radius(rsp_radius),
      .rsp_overflow(rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned floor_root(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // accumulate one accepted vertex; on the last one, queue the expected sphere
   task automatic predict_sphere(vertex_type v);
      sphere_type s;
      longint  cx, cy, cz, dx, dy, dz;
      longint unsigned d, dmax;
      if (mesh_count < StoreDepth) begin
         mesh_x[mesh_count] = v.x;
         mesh_y[mesh_count] = v.y;
         mesh_z[mesh_count] = v.z;
         mesh_sum_x += v.x;
         mesh_sum_y += v.y;
         mesh_sum_z += v.z;
         mesh_count++;
      end else begin
         mesh_dropped = 1'b1;
      end
      if (v.last) begin
         cx = 0; cy = 0; cz = 0; dmax = 0;
         if (mesh_count != 0) begin
            // longint division truncates toward zero
            cx = mesh_sum_x / mesh_count;
            cy = mesh_sum_y / mesh_count;
            cz = mesh_sum_z / mesh_count;
         end
         for (int i = 0; i < mesh_count; i++) begin
            dx = longint'(mesh_x[i]) - cx;
            dy = longint'(mesh_y[i]) - cy;
            dz = longint'(mesh_z[i]) - cz;
            d = dx * dx + dy * dy + dz * dz;
            if (d > dmax) dmax = d;
         end
         s.cx = cx[23:0];
         s.cy = cy[23:0];
         s.cz = cz[23:0];
         s.radius = 25'(floor_root(dmax));
         s.overflow = mesh_dropped;
         if (mesh_dropped) overflow_meshes++;
         sphere_queue = {sphere_queue, s};
         mesh_sum_x = 0; mesh_sum_y = 0; mesh_sum_z = 0;
         mesh_count = 0;
         mesh_dropped = 1'b0;
      end
   endtask

   function automatic logic [23:0] pick_coord();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom_range(0, 255));
         3: return -24'($urandom_range(0, 255));
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic push_vertex(logic [23:0] x, logic [23:0] y, logic [23:0] z, logic last);
      vertex_type v;
      v.x = x; v.y = y; v.z = z; v.last = last;
      vertex_queue = {vertex_queue, v};
   endtask

   task automatic push_mesh(int n);
      for (int i = 0; i < n; i++)
         push_vertex(pick_coord(), pick_coord(), pick_coord(), i == n - 1);
   endtask

   // stimulus and end of run
   initial begin
      int random_total;
      int n;
      mesh_sum_x = 0; mesh_sum_y = 0; mesh_sum_z = 0;
      mesh_count = 0;
      mesh_dropped = 1'b0;

      // single-vertex meshes at the coordinate extremes and at zero
      push_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
      push_vertex(24'h800000, 24'h800000, 24'h800000, 1'b1);
      push_vertex(24'h000000, 24'h000000, 24'h000000, 1'b1);
      // opposite corners: largest radius, centroid rounds toward zero
      push_vertex(24'h800000, 24'h800000, 24'h800000, 1'b0);
      push_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
      push_vertex(24'h800000, 24'h7FFFFF, 24'h800000, 1'b0);
      push_vertex(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b1);
      // negative sums that truncate toward zero
      push_vertex(-24'sd3, -24'sd5, 24'sd7, 1'b0);
      push_vertex(24'sd0, 24'sd0, 24'sd0, 1'b0);
      push_vertex(24'sd0, 24'sd1, -24'sd1, 1'b1);
      push_mesh(3);

      random_total = 0;
      while (random_total < RandomVerts) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
         push_mesh(n);
         random_total += n;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (vertex_queue.size() != 0 || req_valid || sphere_queue.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Run covered %0d vertices in %0d meshes, %0d of them with store overflow.",
               verts_sent, meshes_checked, overflow_meshes);
      if (mismatch_count == 0 && sphere_queue.size() == 0 && !rsp_valid)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // driver: offers queued vertices with random gaps between them
   always @(posedge clock) begin : driver
      int gap;
      vertex_type held;
      if (reset) begin
         req_valid <= 1'b0;
         gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_sphere(held);
            verts_sent++;
         end
         if (!req_valid || req_ready) begin
            if (gap > 0) begin
               gap--;
               req_valid <= 1'b0;
            end else if (vertex_queue.size() != 0) begin
               held = vertex_queue.pop_front();
               req_vertex_x <= held.x;
               req_vertex_y <= held.y;
               req_vertex_z <= held.z;
               req_last_vertex <= held.last;
               req_valid <= 1'b1;
               // every third stretch of 40 vertices goes back to back
               gap = ((verts_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 14);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back-pressure, checks each response transfer
   always @(posedge clock) begin : monitor
      int stall;
      sphere_type s;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sphere_queue.size() == 0) begin
               $error("unexpected response: center_x %0d", rsp_center_x);
               mismatch_count++;
            end else begin
               s = sphere_queue.pop_front();
               if (rsp_center_x !== s.cx) begin
                  $error("center_x expected %0d got %0d", s.cx, rsp_center_x);
                  mismatch_count++;
               end
               if (rsp_center_y !== s.cy) begin
                  $error("center_y expected %0d got %0d", s.cy, rsp_center_y);
                  mismatch_count++;
               end
               if (rsp_center_z !== s.cz) begin
                  $error("center_z expected %0d got %0d", s.cz, rsp_center_z);
                  mismatch_count++;
               end
               if (rsp_radius !== s.radius) begin
                  $error("radius expected %0d got %0d", s.radius, rsp_radius);
                  mismatch_count++;
               end
               if (rsp_overflow !== s.overflow) begin
                  $error("overflow expected %0d got %0d", s.overflow, rsp_overflow);
                  mismatch_count++;
               end
            end
            meshes_checked++;
            // one long hold-off so later meshes back up into the input
            if (meshes_checked == 20) stall = 600;
            else if ((meshes_checked / 8) % 3 == 1) stall = 0;
            else stall = $urandom_range(0, 14);
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end
endmodule
